[sv/hbc_pkg.sv]
`timescale 1ns / 1ps

package hbc_pkg;

    // symbol coding: 0 A, 1 T, 2 C, 3 G
    localparam int SYM_W   = 2;
    localparam int RUN_W   = 3;
    localparam int CFG_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_RUN = 5;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0] nucleotide;
        logic             last_in;
    } t_in;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic             last_out;
    } t_out;

    // substitution tables, indexed by {left, right}
    localparam logic [SYM_W-1:0] TAB_LEFT [16] = '{
        2'd2, 2'd3, 2'd3, 2'd1,
        2'd3, 2'd0, 2'd0, 2'd2,
        2'd3, 2'd0, 2'd0, 2'd1,
        2'd1, 2'd2, 2'd1, 2'd0
    };

    localparam logic [SYM_W-1:0] TAB_RIGHT [16] = '{
        2'd1, 2'd2, 2'd1, 2'd2,
        2'd2, 2'd3, 2'd3, 2'd0,
        2'd1, 2'd3, 2'd1, 2'd0,
        2'd2, 2'd0, 2'd0, 2'd1
    };

    function automatic logic [SYM_W-1:0] tab_left(input logic [SYM_W-1:0] l,
                                                  input logic [SYM_W-1:0] r);
        return TAB_LEFT[{l, r}];
    endfunction

    function automatic logic [SYM_W-1:0] tab_right(input logic [SYM_W-1:0] l,
                                                   input logic [SYM_W-1:0] r);
        return TAB_RIGHT[{l, r}];
    endfunction

endpackage

[sv/hbc_front.sv]
`timescale 1ns / 1ps

module hbc_front #(
    parameter int MAX_RUN = hbc_pkg::MAX_RUN,
    localparam int STORE_DEPTH = 2 * MAX_RUN + 2,
    localparam int JOB_SYMS = 2 * MAX_RUN + 3,
    localparam int FILL_W = $clog2(STORE_DEPTH + 1),
    localparam int CNT_W = $clog2(JOB_SYMS + 1),
    localparam int JOB_W = JOB_SYMS * hbc_pkg::SYM_W + CNT_W + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hbc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hbc_pkg::t_in                  i_in,
    input  logic                          i_q_ready,
    output logic                          o_push,
    output logic [JOB_W-1:0]              o_job
);

    localparam int SW = hbc_pkg::SYM_W;

    logic [hbc_pkg::RUN_W-1:0] r_run_limit;
    logic                      r_dir;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic                      r_even, n_even;
    logic [SW-1:0]             r_blk [STORE_DEPTH];
    logic [SW-1:0]             r_ls, r_ms, r_rs, r_lst, r_chk;

    logic [FILL_W-1:0] w_run, w_s, w_len, w_n1, w_wr_idx;
    logic [FILL_W-1:0] w_idx_ls, w_idx_rs, w_idx_lst;
    logic              w_acc, w_case_a, w_raw, w_proc_last, w_last;
    logic [SW-1:0]     w_sym, w_la;
    logic [SW-1:0]     e_ls, e_ms, e_rs, e_lst, e_chk;
    logic [SW-1:0]     w_eblk [JOB_SYMS];
    logic              w_subst_l, w_subst_r;
    logic [SW-1:0]     w_chk_enc, w_expect, w_mid;
    logic [CNT_W-1:0]  w_cnt;
    logic [JOB_SYMS*SW-1:0] w_syms;

    assign w_sym      = i_in.nucleotide;
    assign w_last     = i_in.last_in;
    assign o_in_ready = i_q_ready;
    assign w_acc      = i_in_valid && i_q_ready;

    // clamp the run length and derive block geometry
    always_comb begin
        if (r_run_limit == '0) begin
            w_run = FILL_W'(1);
        end else if (FILL_W'(r_run_limit) > FILL_W'(MAX_RUN)) begin
            w_run = FILL_W'(MAX_RUN);
        end else begin
            w_run = FILL_W'(r_run_limit);
        end
    end

    assign w_s       = (w_run << 1) + FILL_W'(1);
    assign w_len     = w_s + FILL_W'(r_dir);
    assign w_n1      = (r_dir == hbc_pkg::DIR_DECODE) ? w_s : w_s + FILL_W'(1);
    assign w_idx_ls  = w_run - FILL_W'(1);
    assign w_idx_rs  = w_run + FILL_W'(1);
    assign w_idx_lst = w_s - FILL_W'(1);

    // classify the beat: full block waiting, final partial, or final full
    assign w_case_a    = (r_fill >= w_len);
    assign w_wr_idx    = w_case_a ? '0 : r_fill;
    assign w_proc_last = !w_case_a && w_last && ((r_fill + FILL_W'(1)) >= w_len);
    assign w_raw       = !w_case_a && w_last && !w_proc_last;
    assign w_la        = w_case_a ? w_sym : '0;

    // block contents with the current symbol folded in
    assign e_ls  = (r_fill == w_idx_ls)  ? w_sym : r_ls;
    assign e_ms  = (r_fill == w_run)     ? w_sym : r_ms;
    assign e_rs  = (r_fill == w_idx_rs)  ? w_sym : r_rs;
    assign e_lst = (r_fill == w_idx_lst) ? w_sym : r_lst;
    assign e_chk = (r_fill == w_s)       ? w_sym : r_chk;

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            w_eblk[i] = (r_fill == FILL_W'(i)) ? w_sym : r_blk[i];
        end
        w_eblk[STORE_DEPTH] = w_sym;
    end

    // substitution, check symbol and middle repair
    assign w_subst_l = (e_ls == e_ms);
    assign w_subst_r = !w_subst_l && (e_ms == e_rs);
    assign w_chk_enc = (r_even == (w_subst_l || w_subst_r)) ? hbc_pkg::tab_left(e_lst, w_la)
                                                           : hbc_pkg::tab_right(e_lst, w_la);
    assign w_expect  = r_even ? hbc_pkg::tab_right(e_lst, w_la)
                              : hbc_pkg::tab_left(e_lst, w_la);

    always_comb begin
        if (r_dir == hbc_pkg::DIR_DECODE) begin
            if (e_chk != w_expect) begin
                w_mid = (hbc_pkg::tab_left(e_ls, e_rs) == e_ms) ? e_ls : e_rs;
            end else begin
                w_mid = e_ms;
            end
        end else if (w_subst_l) begin
            w_mid = hbc_pkg::tab_left(e_ls, e_rs);
        end else if (w_subst_r) begin
            w_mid = hbc_pkg::tab_right(e_ls, e_rs);
        end else begin
            w_mid = e_ms;
        end
    end

    // assemble the output job
    always_comb begin
        for (int i = 0; i < JOB_SYMS; i++) begin
            if (w_raw) begin
                w_syms[i*SW +: SW] = w_eblk[i];
            end else if (FILL_W'(i) < w_s) begin
                w_syms[i*SW +: SW] = (FILL_W'(i) == w_run) ? w_mid : w_eblk[i];
            end else if (FILL_W'(i) == w_s && r_dir == hbc_pkg::DIR_ENCODE) begin
                w_syms[i*SW +: SW] = w_chk_enc;
            end else begin
                w_syms[i*SW +: SW] = w_sym;
            end
        end
        if (w_raw) begin
            w_cnt = CNT_W'(r_fill) + CNT_W'(1);
        end else begin
            w_cnt = CNT_W'(w_n1) + CNT_W'(w_case_a && w_last);
        end
    end

    assign o_push = w_acc && (w_case_a || w_last);
    assign o_job  = {w_last, w_cnt, w_syms};

    // next fill level and turn parity
    always_comb begin
        n_fill = w_case_a ? FILL_W'(1) : r_fill + FILL_W'(1);
        n_even = (w_case_a || w_proc_last) ? !r_even : r_even;
        if (w_last) begin
            n_fill = '0;
            n_even = 1'b1;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_limit <= hbc_pkg::RUN_W'(1);
            r_dir       <= hbc_pkg::DIR_ENCODE;
            r_fill      <= '0;
            r_even      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hbc_pkg::REG_RUN_LIMIT: r_run_limit <= i_cfg_data;
                hbc_pkg::REG_DIRECTION: r_dir <= i_cfg_data[0];
                default: ;
            endcase
            r_fill <= '0;
            r_even <= 1'b1;
        end else if (w_acc) begin
            r_fill <= n_fill;
            r_even <= n_even;
        end
    end

    // store the symbol and capture the key positions
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (w_wr_idx == FILL_W'(i)) begin
                    r_blk[i] <= w_sym;
                end
            end
            if (w_wr_idx == w_idx_ls)  r_ls  <= w_sym;
            if (w_wr_idx == w_run)     r_ms  <= w_sym;
            if (w_wr_idx == w_idx_rs)  r_rs  <= w_sym;
            if (w_wr_idx == w_idx_lst) r_lst <= w_sym;
            if (w_wr_idx == w_s)       r_chk <= w_sym;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill level beyond block length");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (w_cnt != '0))
        else $error("empty job pushed");
`endif

endmodule

[sv/hbc_queue.sv]
`timescale 1ns / 1ps

module hbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hbc_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_pop;

    assign o_ready  = (r_cnt != CNT_W'(DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(w_do_pop);
        end
    end

    // hold job payloads
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue occupancy out of range");
`endif

endmodule

[sv/hbc_back.sv]
`timescale 1ns / 1ps

module hbc_back #(
    parameter int MAX_RUN = hbc_pkg::MAX_RUN,
    localparam int JOB_SYMS = 2 * MAX_RUN + 3,
    localparam int CNT_W = $clog2(JOB_SYMS + 1),
    localparam int JOB_W = JOB_SYMS * hbc_pkg::SYM_W + CNT_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [JOB_W-1:0] i_q_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hbc_pkg::t_out    o_out
);

    localparam int SW = hbc_pkg::SYM_W;

    logic [JOB_SYMS*SW-1:0] r_sh;
    logic [CNT_W-1:0]       r_rem;
    logic                   r_last;
    logic                   r_busy;
    logic                   w_take, w_final;

    assign w_take  = r_busy && i_out_ready;
    assign w_final = (r_rem == CNT_W'(1));
    assign o_pop   = i_q_valid && (!r_busy || (w_take && w_final));

    assign o_out_valid      = r_busy;
    assign o_out.symbol_out = r_sh[SW-1:0];
    assign o_out.last_out   = r_last && w_final;

    // load a job or shift out the next symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_rem  <= i_q_job[JOB_SYMS*SW +: CNT_W];
        end else if (w_take) begin
            r_rem  <= r_rem - CNT_W'(1);
            r_busy <= !w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sh   <= i_q_job[JOB_SYMS*SW-1:0];
            r_last <= i_q_job[JOB_W-1];
        end else if (w_take) begin
            r_sh   <= r_sh >> SW;
        end
    end

`ifndef ASSERT_OFF
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem != '0))
        else $error("busy with no symbols left");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_busy)
        else $error("popped job not loaded");
`endif

endmodule

[sv/homopolymer_block_codec_top.sv]
`timescale 1ns / 1ps

// Homopolymer-limiting block codec for nucleotide streams (A=0, T=1, C=2, G=3).
// Input channel: i_in_valid / o_in_ready, one symbol per beat, last_in marks
// the end of a stream. Output channel: o_out_valid / i_out_ready, one symbol
// per beat, last_out on the final symbol of a stream.
// Configuration: i_cfg_we with i_cfg_idx (0 run_limit, 1 direction) and
// i_cfg_data; write only while idle. A write drops any partial block.
// The front end buffers a block and, on the lookahead beat (or stream end),
// builds a whole output job in the same cycle; jobs wait in a two-entry queue.
// The back end plays a job out one symbol per cycle from its output register while i_out_ready is high.
// When the back end is idle, a completed job is written into the queue and then
// loaded into the back end's output register, where its first symbol is valid.
// Throughput: one output symbol per cycle while i_out_ready is high. Encode turns
// 2R+1 beats into 2R+2 symbols, so the input runs slower than the output; decode
// turns 2R+2 beats into 2R+1 symbols and takes one beat per cycle unless the queue is full.
// Reset: empty buffers, run_limit 1, encode, even turn first.
// If the receiver stalls, the back end holds its symbol, the queue fills
// and o_in_ready drops until a queue slot frees.
module homopolymer_block_codec_top #(
    parameter int MAX_RUN = hbc_pkg::MAX_RUN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hbc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hbc_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hbc_pkg::t_out                 o_out
);

    localparam int JOB_SYMS = 2 * MAX_RUN + 3;
    localparam int CNT_W = $clog2(JOB_SYMS + 1);
    localparam int JOB_W = JOB_SYMS * hbc_pkg::SYM_W + CNT_W + 1;

    logic             w_push, w_q_ready, w_q_valid, w_pop;
    logic [JOB_W-1:0] w_job_in, w_job_out;

    hbc_front #(.MAX_RUN(MAX_RUN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    hbc_queue #(.WIDTH(JOB_W), .DEPTH(hbc_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_job_out)
    );

    hbc_back #(.MAX_RUN(MAX_RUN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[test/tb_homopolymer_block_codec_top.sv]
`timescale 1ns / 1ps

module tb_homopolymer_block_codec_top;

    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 250;
    localparam int WATCHDOG    = 3000;
    localparam int PHASE_BEATS = 19;
    localparam int NUM_PHASES  = 9;

    localparam logic [hbc_pkg::SYM_W-1:0] SYM_A = 2'd0;
    localparam logic [hbc_pkg::SYM_W-1:0] SYM_T = 2'd1;
    localparam logic [hbc_pkg::SYM_W-1:0] SYM_C = 2'd2;
    localparam logic [hbc_pkg::SYM_W-1:0] SYM_G = 2'd3;

    // One input beat, plus an optional hand-typed expectation for it
    typedef struct packed {
        hbc_pkg::t_in  item;
        logic          has_lit;
        hbc_pkg::t_out lit;
    } t_beat;

    // Software copy of the codec state
    typedef struct packed {
        logic [2*(2*hbc_pkg::MAX_RUN+2)-1:0] held;
        logic [3:0]                          fill;
        logic                                even;
        logic [hbc_pkg::RUN_W-1:0]           run;
        logic                                dir;
    } t_codec_state;

    // Directed stream at reset settings (R = 1, encode):
    // {symbol, last, has_lit, lit symbol, lit last}
    localparam t_beat SEED_BEATS [20] = '{
        {SYM_G, 1'b1, 1'b1, SYM_G, 1'b1},  // lone symbol stream
        {SYM_A, 1'b1, 1'b1, SYM_A, 1'b1},
        {SYM_A, 1'b0, 4'b0},               // middle repeats left
        {SYM_A, 1'b0, 4'b0},
        {SYM_A, 1'b0, 4'b0},
        {SYM_C, 1'b0, 4'b0},               // middle repeats right
        {SYM_T, 1'b0, 4'b0},
        {SYM_T, 1'b0, 4'b0},
        {SYM_G, 1'b0, 4'b0},               // no repeat
        {SYM_C, 1'b0, 4'b0},
        {SYM_A, 1'b0, 4'b0},
        {SYM_T, 1'b0, 4'b0},               // stream ends on a full block
        {SYM_T, 1'b0, 4'b0},
        {SYM_T, 1'b1, 4'b0},
        {SYM_C, 1'b0, 4'b0},               // stream ends on a partial block
        {SYM_G, 1'b1, 4'b0},
        {SYM_G, 1'b0, 4'b0},               // ends on the lone lookahead symbol
        {SYM_G, 1'b0, 4'b0},
        {SYM_G, 1'b0, 4'b0},
        {SYM_A, 1'b1, 4'b0}
    };

    // Register settings per random phase, extremes and out-of-range runs included
    localparam logic [hbc_pkg::RUN_W-1:0] RUN_PLAN [NUM_PHASES] = '{
        3'd5, 3'd0, 3'd7, 3'd3, 3'd1, 3'd2, 3'd6, 3'd4, 3'd5
    };
    localparam logic DIR_PLAN [NUM_PHASES] = '{
        hbc_pkg::DIR_ENCODE, hbc_pkg::DIR_ENCODE, hbc_pkg::DIR_DECODE,
        hbc_pkg::DIR_DECODE, hbc_pkg::DIR_DECODE, hbc_pkg::DIR_ENCODE,
        hbc_pkg::DIR_ENCODE, hbc_pkg::DIR_DECODE, hbc_pkg::DIR_DECODE
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hbc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [hbc_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    hbc_pkg::t_in                  i_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    hbc_pkg::t_out                 o_out;

    t_beat         beat_q [$];
    hbc_pkg::t_out expected_q [$];
    hbc_pkg::t_out coded_q [$];
    t_beat         offer;
    t_codec_state  codec_st;
    int            err_cnt = 0;
    int            out_cnt = 0;
    int            idle_cycles = 0;
    bit            no_idle = 1'b0;
    bit            long_hold = 1'b0;

    homopolymer_block_codec_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Substitution tables, each entry packed as {left, right}
    function automatic logic [1:0] subst_lut(input logic from_left, input logic [1:0] l,
                                             input logic [1:0] r);
        logic [3:0] pair;
        case ({l, r})
            4'h0: pair = {2'd2, 2'd1};
            4'h1: pair = {2'd3, 2'd2};
            4'h2: pair = {2'd3, 2'd1};
            4'h3: pair = {2'd1, 2'd2};
            4'h4: pair = {2'd3, 2'd2};
            4'h5: pair = {2'd0, 2'd3};
            4'h6: pair = {2'd0, 2'd3};
            4'h7: pair = {2'd2, 2'd0};
            4'h8: pair = {2'd3, 2'd1};
            4'h9: pair = {2'd0, 2'd3};
            4'ha: pair = {2'd0, 2'd1};
            4'hb: pair = {2'd1, 2'd0};
            4'hc: pair = {2'd1, 2'd2};
            4'hd: pair = {2'd2, 2'd0};
            4'he: pair = {2'd1, 2'd0};
            default: pair = {2'd0, 2'd1};
        endcase
        return from_left ? pair[3:2] : pair[1:0];
    endfunction

    function automatic int eff_run(input logic [hbc_pkg::RUN_W-1:0] run);
        if (run == 0) return 1;
        if (run > hbc_pkg::MAX_RUN) return hbc_pkg::MAX_RUN;
        return int'(run);
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_sym(input bit narrow, input logic [1:0] a,
                                            input logic [1:0] c);
        if (narrow) return $urandom_range(0, 1) ? a : c;
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Advance the codec state by one symbol; queue the symbols it releases
    // either as expectations or as a coded stream for the decoder
    task automatic codec_beat(inout t_codec_state st, input logic [1:0] sym,
                              input logic last, input bit to_expected);
        int            r, s, blen, n, k;
        logic [1:0]    ls, ms, rs, lst, la, mid, chk;
        logic          pre, post, subst;
        hbc_pkg::t_out res [13];
        hbc_pkg::t_out cur;
        r    = eff_run(st.run);
        s    = 2 * r + 1;
        blen = s + int'(st.dir);
        n    = 0;
        pre  = (st.fill >= blen);
        post = 1'b0;
        if (!pre) begin
            st.held[2*st.fill +: 2] = sym;
            st.fill = st.fill + 4'd1;
            post = last && (st.fill >= blen);
        end
        // Fold a full block, on the next symbol or on stream end
        if (pre || post) begin
            la  = pre ? sym : SYM_A;
            ls  = st.held[2*(r-1) +: 2];
            ms  = st.held[2*r +: 2];
            rs  = st.held[2*(r+1) +: 2];
            lst = st.held[2*(s-1) +: 2];
            mid = ms;
            chk = SYM_A;
            if (st.dir == hbc_pkg::DIR_ENCODE) begin
                subst = 1'b1;
                if (ls == ms) mid = subst_lut(1'b1, ls, rs);
                else if (ms == rs) mid = subst_lut(1'b0, ls, rs);
                else subst = 1'b0;
                chk = subst_lut(st.even == subst, lst, la);
            end else if (st.held[2*s +: 2] != subst_lut(!st.even, lst, la)) begin
                mid = (subst_lut(1'b1, ls, rs) == ms) ? ls : rs;
            end
            for (k = 0; k < s; k++) begin
                res[n] = {(k == r) ? mid : st.held[2*k +: 2], 1'b0};
                n++;
            end
            if (st.dir == hbc_pkg::DIR_ENCODE) begin
                res[n] = {chk, 1'b0};
                n++;
            end
            st.even = !st.even;
        end
        if (pre) begin
            st.held[1:0] = sym;
            st.fill = 4'd1;
        end
        // Close the stream: flush a partial block and restart the turn
        if (last) begin
            if (!post) begin
                for (k = 0; k < st.fill; k++) begin
                    res[n] = {st.held[2*k +: 2], 1'b0};
                    n++;
                end
            end
            st.fill = '0;
            st.even = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            cur = res[k];
            cur.last_out = last && (k == n - 1);
            if (to_expected) expected_q.push_back(cur);
            else coded_q.push_back(cur);
        end
    endtask

    task automatic write_reg(input logic [hbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hbc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == hbc_pkg::REG_RUN_LIMIT) codec_st.run = val;
        else codec_st.dir = val[0];
        codec_st.fill = '0;
        codec_st.even = 1'b1;
    endtask

    // Hold until every beat is sent and every expected symbol is back
    task automatic wait_idle();
        while (beat_q.size() > 0 || i_in_valid || expected_q.size() > 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Offer queued beats with random gaps
    initial begin : beat_sender
        int    hold;
        t_beat b;
        hold = 0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        offer      <= '0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && (!i_in_valid || o_in_ready)) begin
                if (hold > 0) begin
                    hold--;
                    i_in_valid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    b = beat_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in       <= b.item;
                    offer      <= b;
                    hold = gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the output side at random, once for a long stretch
    initial begin : result_receiver
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // Predict on every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            codec_beat(codec_st, i_in.nucleotide, i_in.last_in, !offer.has_lit);
            if (offer.has_lit) expected_q.push_back(offer.lit);
        end
    end

    // Compare every output beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        hbc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_cnt++;
            if (expected_q.size() == 0) begin
                note_error($sformatf("out beat %0d unexpected: symbol_out %0d last_out %0b",
                                     out_cnt, o_out.symbol_out, o_out.last_out));
            end else begin
                want = expected_q.pop_front();
                if (o_out.symbol_out !== want.symbol_out)
                    note_error($sformatf("out beat %0d symbol_out: exp %0d got %0d",
                                         out_cnt, want.symbol_out, o_out.symbol_out));
                if (o_out.last_out !== want.last_out)
                    note_error($sformatf("out beat %0d last_out: exp %0b got %0b",
                                         out_cnt, want.last_out, o_out.last_out));
            end
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb_homopolymer_block_codec_top: done, errors");
                $finish;
            end
        end
    end

    initial begin : main_seq
        int            ph, k, len, unit, blk;
        int            sent;
        logic [1:0]    sa, sb;
        bit            narrow;
        t_codec_state  enc_st;
        t_beat         b;
        hbc_pkg::t_out o;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        codec_st = '0;
        codec_st.even = 1'b1;
        codec_st.run  = 3'd1;
        codec_st.dir  = hbc_pkg::DIR_ENCODE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table at reset settings
        foreach (SEED_BEATS[k]) beat_q.push_back(SEED_BEATS[k]);
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if ($urandom_range(0, 1)) begin
                write_reg(hbc_pkg::REG_RUN_LIMIT, RUN_PLAN[ph]);
                write_reg(hbc_pkg::REG_DIRECTION, hbc_pkg::CFG_W'(DIR_PLAN[ph]));
            end else begin
                write_reg(hbc_pkg::REG_DIRECTION, hbc_pkg::CFG_W'(DIR_PLAN[ph]));
                write_reg(hbc_pkg::REG_RUN_LIMIT, RUN_PLAN[ph]);
            end
            no_idle = (ph % 3 == 2);
            // Short blocks fill the queue fast, so the input stalls under the hold
            if (ph == 1) long_hold = 1'b1;
            blk  = 2 * eff_run(RUN_PLAN[ph]) + 1;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                narrow = 1'($urandom_range(0, 1));
                sa = 2'($urandom_range(0, 3));
                sb = 2'($urandom_range(0, 3));
                if (DIR_PLAN[ph] == hbc_pkg::DIR_DECODE && $urandom_range(0, 3) != 0) begin
                    // Encode random data so the decoder sees a clean stream
                    len = ($urandom_range(0, 2) == 0) ? blk * $urandom_range(1, 2)
                                                      : $urandom_range(1, 3 * blk + 1);
                    enc_st = '0;
                    enc_st.even = 1'b1;
                    enc_st.run  = RUN_PLAN[ph];
                    enc_st.dir  = hbc_pkg::DIR_ENCODE;
                    coded_q.delete();
                    for (k = 0; k < len; k++)
                        codec_beat(enc_st, pick_sym(narrow, sa, sb), k == len - 1, 1'b0);
                    while (coded_q.size() > 0) begin
                        o = coded_q.pop_front();
                        b = '0;
                        b.item = {o.symbol_out, o.last_out};
                        beat_q.push_back(b);
                        sent++;
                    end
                end else begin
                    unit = blk + int'(DIR_PLAN[ph]);
                    len = ($urandom_range(0, 2) == 0) ? unit * $urandom_range(1, 2)
                                                      : $urandom_range(1, 3 * unit + 1);
                    for (k = 0; k < len; k++) begin
                        b = '0;
                        b.item = {pick_sym(narrow, sa, sb), k == len - 1};
                        beat_q.push_back(b);
                        sent++;
                    end
                end
            end
            // Leave the stream open on odd phases; the next write drops it
            if (ph % 2 == 1) begin
                b = beat_q.pop_back();
                b.item.last_in = 1'b0;
                beat_q.push_back(b);
            end
            wait_idle();
        end

        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("tb_homopolymer_block_codec_top: done, clean");
        end else begin
            $display("tb_homopolymer_block_codec_top: done, errors");
        end
        $finish;
    end

endmodule
